@@ hdl/lsst_pkg.sv @@
// shared types, codes and constants of the lock site statistics table
package lsst_pkg;

	localparam int TABLE_SLOTS_DEF = 512;

	localparam int KEY_W   = 32;
	localparam int LOCK_W  = 32;
	localparam int TICK_W  = 63;
	localparam int SLOT_W  = 9;
	localparam int REM_W   = 10;
	localparam int STAT_W  = 3;

	localparam logic [KEY_W-1:0] KEY_EMPTY = 32'd0;
	localparam logic [KEY_W-1:0] KEY_TOMB  = 32'd1;

	typedef enum logic [1:0] {
		FUNC_RECORD = 2'd0,
		FUNC_DELIST = 2'd1,
		FUNC_READ   = 2'd2
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_UPDATED  = 3'd0,
		STAT_INSERTED = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_BAD_KEY  = 3'd3,
		STAT_DELISTED = 3'd4,
		STAT_READ     = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_REC_RD,
		S_REC_CHK,
		S_DEL_RD,
		S_DEL_CHK,
		S_DEL_DONE,
		S_RD_RD,
		S_RD_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_PROBE,
		RD_SWEEP,
		RD_SLOT
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_CLEAR,
		WR_REC,
		WR_TOMB
	} wr_sel_t;

	typedef enum logic [1:0] {
		RES_REC,
		RES_READ,
		RES_ZERO,
		RES_DEL
	} res_sel_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [LOCK_W-1:0] lock;
		logic [TICK_W-1:0] takes;
		logic [TICK_W-1:0] total;
		logic [TICK_W-1:0] max;
	} entry_t;

	typedef struct packed {
		logic     load_in;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     wr_en;
		wr_sel_t  wr_sel;
		logic     probe_step;
		logic     cnt_inc;
		logic     emit;
		res_sel_t res_sel;
		status_t  status;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
		logic bad_key;
		logic hit;
		logic empty;
		logic tomb_avail;
		logic cnt_last;
		logic del_match;
	} dp_stat_t;

endpackage

@@ hdl/lsst_ram.sv @@
// generic single write port ram with registered read
module lsst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/lsst_datapath.sv @@
// table storage, probe registers, entry update and result register
module lsst_datapath #(
	parameter int TABLE_SLOTS = lsst_pkg::TABLE_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lsst_pkg::cmd_t               cmd,
	output lsst_pkg::dp_stat_t           stat,
	input  logic [lsst_pkg::KEY_W-1:0]   site_key,
	input  logic [lsst_pkg::LOCK_W-1:0]  lock_id,
	input  logic [lsst_pkg::TICK_W-1:0]  acquire_tick,
	input  logic [lsst_pkg::TICK_W-1:0]  now_tick,
	input  logic [lsst_pkg::SLOT_W-1:0]  read_slot,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lsst_pkg::STAT_W-1:0]  status,
	output logic [lsst_pkg::SLOT_W-1:0]  slot_index,
	output logic [lsst_pkg::KEY_W-1:0]   key_out,
	output logic [lsst_pkg::LOCK_W-1:0]  lock_id_out,
	output logic [lsst_pkg::TICK_W-1:0]  take_count,
	output logic [lsst_pkg::TICK_W-1:0]  total_hold,
	output logic [lsst_pkg::TICK_W-1:0]  max_hold,
	output logic [lsst_pkg::REM_W-1:0]   removed_count
);

	import lsst_pkg::*;

	localparam int IW = $clog2(TABLE_SLOTS);

	logic [KEY_W-1:0]  key_q;
	logic [LOCK_W-1:0] lid_q;
	logic [TICK_W-1:0] hold_q;
	logic [IW-1:0]     rs_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     stride_q;
	logic [IW-1:0]     tomb_q;
	logic              have_tomb_q;
	logic [IW-1:0]     cnt_q;
	logic [IW:0]       rem_q;
	logic              out_valid_q;

	logic [TICK_W:0]    hold_diff;
	logic [KEY_W-1:0]   key_odd;
	logic [IW+SLOT_W-1:0] rs_ext;

	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	entry_t            ram_wdata;
	logic [IW-1:0]     ram_raddr;
	logic [$bits(entry_t)-1:0] ram_rdata;
	entry_t            rd_ent;

	logic              hit;
	logic              rd_tomb;
	logic [IW-1:0]     rec_tgt;
	entry_t            upd_ent;
	entry_t            new_ent;
	entry_t            res_ent;
	logic [IW-1:0]     res_slot;
	logic [IW+SLOT_W-1:0] res_slot_ext;
	logic [IW+REM_W:0] rem_ext;

	// clamped hold time, borrow out of the subtraction means negative
	assign hold_diff = {1'b0, now_tick} - {1'b0, acquire_tick};
	assign key_odd   = site_key | 32'd1;
	assign rs_ext    = {{IW{1'b0}}, read_slot};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_tomb_q <= 1'b0;
			cnt_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				have_tomb_q <= 1'b0;
				cnt_q       <= '0;
				rem_q       <= '0;
			end else begin
				if (cmd.probe_step && !have_tomb_q && rd_tomb) begin
					have_tomb_q <= 1'b1;
				end
				if (cmd.cnt_inc || cmd.probe_step) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (cmd.wr_en && cmd.wr_sel == WR_TOMB) begin
					rem_q <= rem_q + 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			key_q    <= site_key;
			lid_q    <= lock_id;
			hold_q   <= hold_diff[TICK_W] ? '0 : hold_diff[TICK_W-1:0];
			rs_q     <= rs_ext[IW-1:0];
			idx_q    <= site_key[IW-1:0];
			stride_q <= key_odd[IW-1:0];
		end else if (cmd.probe_step) begin
			if (!have_tomb_q && rd_tomb) begin
				tomb_q <= idx_q;
			end
			idx_q <= idx_q + stride_q;
		end
	end

	assign rd_ent  = entry_t'(ram_rdata);
	assign hit     = rd_ent.key == key_q && rd_ent.lock == lid_q;
	assign rd_tomb = rd_ent.key == KEY_TOMB;
	assign rec_tgt = (hit || !have_tomb_q) ? idx_q : tomb_q;

	always_comb begin
		upd_ent       = rd_ent;
		upd_ent.takes = rd_ent.takes + 1'b1;
		upd_ent.total = rd_ent.total + hold_q;
		upd_ent.max   = (hold_q > rd_ent.max) ? hold_q : rd_ent.max;
		if (hit) begin
			new_ent = upd_ent;
		end else begin
			// claimed tombstones and empty slots always carry zero statistics
			new_ent.key   = key_q;
			new_ent.lock  = lid_q;
			new_ent.takes = {{(TICK_W-1){1'b0}}, 1'b1};
			new_ent.total = hold_q;
			new_ent.max   = hold_q;
		end
	end

	always_comb begin
		ram_we    = cmd.wr_en;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		case (cmd.wr_sel)
			WR_CLEAR: begin
				ram_waddr = cnt_q;
				ram_wdata = '0;
			end
			WR_REC: begin
				ram_waddr = rec_tgt;
				ram_wdata = new_ent;
			end
			WR_TOMB: begin
				ram_waddr     = cnt_q;
				ram_wdata     = '0;
				ram_wdata.key = KEY_TOMB;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_PROBE: ram_raddr = idx_q;
			RD_SWEEP: ram_raddr = cnt_q;
			RD_SLOT:  ram_raddr = rs_q;
			default:  ram_raddr = idx_q;
		endcase
	end

	lsst_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_en),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		case (cmd.res_sel)
			RES_REC: begin
				res_ent  = new_ent;
				res_slot = rec_tgt;
			end
			RES_READ: begin
				res_ent  = rd_ent;
				res_slot = rs_q;
			end
			default: begin
				res_ent  = '0;
				res_slot = '0;
			end
		endcase
	end

	assign res_slot_ext = {{SLOT_W{1'b0}}, res_slot};
	assign rem_ext      = {{REM_W{1'b0}}, rem_q};

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status        <= cmd.status;
			slot_index    <= res_slot_ext[SLOT_W-1:0];
			key_out       <= res_ent.key;
			lock_id_out   <= res_ent.lock;
			take_count    <= res_ent.takes;
			total_hold    <= res_ent.total;
			max_hold      <= res_ent.max;
			removed_count <= (cmd.res_sel == RES_DEL) ? rem_ext[REM_W-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;

	assign stat.out_busy   = out_valid_q && !out_ready;
	assign stat.bad_key    = key_q == KEY_EMPTY || key_q == KEY_TOMB;
	assign stat.hit        = hit;
	assign stat.empty      = rd_ent.key == KEY_EMPTY;
	assign stat.tomb_avail = have_tomb_q || rd_tomb;
	assign stat.cnt_last   = cnt_q == IW'(TABLE_SLOTS - 1);
	assign stat.del_match  = rd_ent.key != KEY_EMPTY && rd_ent.key != KEY_TOMB
		&& rd_ent.lock == lid_q;

endmodule

@@ hdl/lsst_ctrl.sv @@
// controller state machine: clearing pass, probe walk, delist sweep, read
module lsst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  lsst_pkg::dp_stat_t stat,
	output lsst_pkg::cmd_t     cmd
);

	import lsst_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.rd_sel     = RD_PROBE;
		cmd.wr_sel     = WR_CLEAR;
		cmd.res_sel    = RES_ZERO;
		cmd.status     = STAT_UPDATED;
		case (state_q)
			S_CLEAR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_CLEAR;
				cmd.cnt_inc = 1'b1;
				if (stat.cnt_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					case (func_t'(func))
						FUNC_RECORD: state_d = S_REC_RD;
						FUNC_DELIST: state_d = S_DEL_RD;
						FUNC_READ:   state_d = S_RD_RD;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_REC_RD: begin
				if (stat.bad_key) begin
					if (!stat.out_busy) begin
						cmd.emit    = 1'b1;
						cmd.res_sel = RES_ZERO;
						cmd.status  = STAT_BAD_KEY;
						state_d     = S_IDLE;
					end
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PROBE;
					state_d    = S_REC_CHK;
				end
			end
			S_REC_CHK: begin
				// read data holds while the result register is busy
				if (stat.hit || stat.empty || (stat.cnt_last && stat.tomb_avail)) begin
					if (!stat.out_busy) begin
						cmd.wr_en   = 1'b1;
						cmd.wr_sel  = WR_REC;
						cmd.emit    = 1'b1;
						cmd.res_sel = RES_REC;
						cmd.status  = stat.hit ? STAT_UPDATED : STAT_INSERTED;
						state_d     = S_IDLE;
					end
				end else if (stat.cnt_last) begin
					if (!stat.out_busy) begin
						cmd.emit    = 1'b1;
						cmd.res_sel = RES_ZERO;
						cmd.status  = STAT_FULL;
						state_d     = S_IDLE;
					end
				end else begin
					cmd.probe_step = 1'b1;
					state_d        = S_REC_RD;
				end
			end
			S_DEL_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_SWEEP;
				state_d    = S_DEL_CHK;
			end
			S_DEL_CHK: begin
				cmd.wr_en   = stat.del_match;
				cmd.wr_sel  = WR_TOMB;
				cmd.cnt_inc = 1'b1;
				state_d     = stat.cnt_last ? S_DEL_DONE : S_DEL_RD;
			end
			S_DEL_DONE: begin
				if (!stat.out_busy) begin
					cmd.emit    = 1'b1;
					cmd.res_sel = RES_DEL;
					cmd.status  = STAT_DELISTED;
					state_d     = S_IDLE;
				end
			end
			S_RD_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_SLOT;
				state_d    = S_RD_DONE;
			end
			S_RD_DONE: begin
				if (!stat.out_busy) begin
					cmd.emit    = 1'b1;
					cmd.res_sel = RES_READ;
					cmd.status  = STAT_READ;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/lock_site_stats_hash_table_unit.sv @@
// top level of the lock site hold-time statistics hash table
//
//   channel  handshake             payload
//   in       in_valid / in_ready   func, site_key, lock_id, acquire_tick, now_tick, read_slot
//   out      out_valid / out_ready status, slot_index, key_out, lock_id_out, take_count,
//                                  total_hold, max_hold, removed_count
//
// a record reads the table ram port once per probed slot; a read fetches the one
// slot named by read_slot, and a delist sweeps every slot of the table.
// after reset a clearing pass writes every slot with in_ready low.
// one transaction is worked at a time; the next is taken while a result waits
// in the output register, and a result is held back until that register is free.
module lock_site_stats_hash_table_unit #(
	parameter int TABLE_SLOTS = lsst_pkg::TABLE_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   func,
	input  logic [lsst_pkg::KEY_W-1:0]   site_key,
	input  logic [lsst_pkg::LOCK_W-1:0]  lock_id,
	input  logic [lsst_pkg::TICK_W-1:0]  acquire_tick,
	input  logic [lsst_pkg::TICK_W-1:0]  now_tick,
	input  logic [lsst_pkg::SLOT_W-1:0]  read_slot,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lsst_pkg::STAT_W-1:0]  status,
	output logic [lsst_pkg::SLOT_W-1:0]  slot_index,
	output logic [lsst_pkg::KEY_W-1:0]   key_out,
	output logic [lsst_pkg::LOCK_W-1:0]  lock_id_out,
	output logic [lsst_pkg::TICK_W-1:0]  take_count,
	output logic [lsst_pkg::TICK_W-1:0]  total_hold,
	output logic [lsst_pkg::TICK_W-1:0]  max_hold,
	output logic [lsst_pkg::REM_W-1:0]   removed_count
);

	import lsst_pkg::*;

	cmd_t     cmd;
	dp_stat_t stat;

	lsst_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func    (func),
		.stat    (stat),
		.cmd     (cmd)
	);

	lsst_datapath #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.site_key     (site_key),
		.lock_id      (lock_id),
		.acquire_tick (acquire_tick),
		.now_tick     (now_tick),
		.read_slot    (read_slot),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.slot_index   (slot_index),
		.key_out      (key_out),
		.lock_id_out  (lock_id_out),
		.take_count   (take_count),
		.total_hold   (total_hold),
		.max_hold     (max_hold),
		.removed_count(removed_count)
	);

endmodule

@@ tb/lock_site_stats_checker.sv @@
// checker that predicts and compares every result of the lock site statistics table
module lock_site_stats_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [1:0]                   func,
	input  logic [lsst_pkg::KEY_W-1:0]   site_key,
	input  logic [lsst_pkg::LOCK_W-1:0]  lock_id,
	input  logic [lsst_pkg::TICK_W-1:0]  acquire_tick,
	input  logic [lsst_pkg::TICK_W-1:0]  now_tick,
	input  logic [lsst_pkg::SLOT_W-1:0]  read_slot,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [lsst_pkg::STAT_W-1:0]  status,
	input  logic [lsst_pkg::SLOT_W-1:0]  slot_index,
	input  logic [lsst_pkg::KEY_W-1:0]   key_out,
	input  logic [lsst_pkg::LOCK_W-1:0]  lock_id_out,
	input  logic [lsst_pkg::TICK_W-1:0]  take_count,
	input  logic [lsst_pkg::TICK_W-1:0]  total_hold,
	input  logic [lsst_pkg::TICK_W-1:0]  max_hold,
	input  logic [lsst_pkg::REM_W-1:0]   removed_count,
	output int                           results_pending,
	output int                           failures
);
	timeunit 1ns;
	timeprecision 1ps;
	import lsst_pkg::*;

	localparam int SLOTS = TABLE_SLOTS_DEF;

	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  slot;
		logic [KEY_W-1:0]   key;
		logic [LOCK_W-1:0]  lock;
		logic [TICK_W-1:0]  takes;
		logic [TICK_W-1:0]  total;
		logic [TICK_W-1:0]  peak;
		logic [REM_W-1:0]   removed;
	} stats_result_t;

	logic [KEY_W-1:0]  site_key_tbl [SLOTS];
	logic [LOCK_W-1:0] lock_tbl     [SLOTS];
	logic [TICK_W-1:0] takes_tbl    [SLOTS];
	logic [TICK_W-1:0] total_tbl    [SLOTS];
	logic [TICK_W-1:0] peak_tbl     [SLOTS];

	stats_result_t expected_stats_q [$];
	int fail_total;

	function automatic stats_result_t entry_view(input status_t st, input logic [SLOT_W-1:0] s);
		stats_result_t r;
		r.status  = st;
		r.slot    = s;
		r.key     = site_key_tbl[s];
		r.lock    = lock_tbl[s];
		r.takes   = takes_tbl[s];
		r.total   = total_tbl[s];
		r.peak    = peak_tbl[s];
		r.removed = '0;
		return r;
	endfunction

	function automatic stats_result_t record_hold(input logic [KEY_W-1:0] k,
			input logic [LOCK_W-1:0] l, input logic [TICK_W-1:0] acq,
			input logic [TICK_W-1:0] nw);
		stats_result_t r;
		logic [SLOT_W-1:0] probe;
		logic [SLOT_W-1:0] stride;
		logic [SLOT_W-1:0] first_tomb;
		logic [SLOT_W-1:0] target;
		logic seen_tomb;
		logic hit;
		logic hit_empty;
		logic [TICK_W-1:0] hold;
		status_t st;
		int n;
		r = '0;
		seen_tomb = 1'b0;
		hit = 1'b0;
		hit_empty = 1'b0;
		first_tomb = '0;
		target = '0;
		probe = k[SLOT_W-1:0];
		stride = k[SLOT_W-1:0] | 1'b1;
		if (k == KEY_EMPTY || k == KEY_TOMB) begin
			r.status = STAT_BAD_KEY;
			return r;
		end
		// odd stride visits every slot; index wraps at the table size
		for (n = 0; n < SLOTS && !hit && !hit_empty; n++) begin
			if (site_key_tbl[probe] == k && lock_tbl[probe] == l) begin
				hit = 1'b1;
				target = probe;
			end else begin
				if (site_key_tbl[probe] == KEY_TOMB && !seen_tomb) begin
					seen_tomb = 1'b1;
					first_tomb = probe;
				end
				if (site_key_tbl[probe] == KEY_EMPTY) begin
					hit_empty = 1'b1;
					target = probe;
				end else begin
					probe = probe + stride;
				end
			end
		end
		if (hit) begin
			st = STAT_UPDATED;
		end else if (seen_tomb || hit_empty) begin
			if (seen_tomb)
				target = first_tomb;
			site_key_tbl[target] = k;
			lock_tbl[target] = l;
			st = STAT_INSERTED;
		end else begin
			r.status = STAT_FULL;
			return r;
		end
		hold = (nw >= acq) ? nw - acq : '0;
		takes_tbl[target] = takes_tbl[target] + 1'b1;
		total_tbl[target] = total_tbl[target] + hold;
		if (hold > peak_tbl[target])
			peak_tbl[target] = hold;
		return entry_view(st, target);
	endfunction

	function automatic stats_result_t delist_lock(input logic [LOCK_W-1:0] l);
		stats_result_t r;
		int cnt;
		int i;
		r = '0;
		cnt = 0;
		for (i = 0; i < SLOTS; i++) begin
			if (site_key_tbl[i] > KEY_TOMB && lock_tbl[i] == l) begin
				site_key_tbl[i] = KEY_TOMB;
				lock_tbl[i] = '0;
				takes_tbl[i] = '0;
				total_tbl[i] = '0;
				peak_tbl[i] = '0;
				cnt++;
			end
		end
		r.status = STAT_DELISTED;
		r.removed = REM_W'(cnt);
		return r;
	endfunction

	function automatic void report_failure(input string what, input stats_result_t want,
			input stats_result_t got);
		fail_total++;
		if (fail_total <= 10) begin
			$display("%0t %s: status %0d/%0d slot %0d/%0d key %h/%h lock %h/%h", $realtime,
				what, want.status, got.status, want.slot, got.slot, want.key, got.key,
				want.lock, got.lock);
			$display("    takes %h/%h total %h/%h max %h/%h removed %0d/%0d (exp/act)",
				want.takes, got.takes, want.total, got.total, want.peak, got.peak,
				want.removed, got.removed);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stats_result_t got;
		stats_result_t want;
		int i;
		if (!arst_n) begin
			for (i = 0; i < SLOTS; i++) begin
				site_key_tbl[i] = KEY_EMPTY;
				lock_tbl[i] = '0;
				takes_tbl[i] = '0;
				total_tbl[i] = '0;
				peak_tbl[i] = '0;
			end
			expected_stats_q.delete();
			fail_total = 0;
			results_pending <= 0;
			failures <= 0;
		end else begin
			// results leave before the transaction taken at the same edge can produce one
			if (out_valid && out_ready) begin
				got.status  = status_t'(status);
				got.slot    = slot_index;
				got.key     = key_out;
				got.lock    = lock_id_out;
				got.takes   = take_count;
				got.total   = total_hold;
				got.peak    = max_hold;
				got.removed = removed_count;
				if (expected_stats_q.size() == 0) begin
					report_failure("unexpected result", '0, got);
				end else begin
					want = expected_stats_q.pop_front();
					if (want !== got)
						report_failure("result mismatch", want, got);
				end
			end
			if (in_valid && in_ready) begin
				case (func)
					FUNC_RECORD: expected_stats_q.push_back(
						record_hold(site_key, lock_id, acquire_tick, now_tick));
					FUNC_DELIST: expected_stats_q.push_back(delist_lock(lock_id));
					FUNC_READ:   expected_stats_q.push_back(entry_view(STAT_READ, read_slot));
					default: ;
				endcase
			end
			results_pending <= expected_stats_q.size();
			failures <= fail_total;
		end
	end

endmodule

@@ tb/lock_site_stats_hash_table_unit_tb.sv @@
// testbench top: stimulus, pacing and verdict for the lock site statistics table
module lock_site_stats_hash_table_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lsst_pkg::*;

	localparam int SLOTS = TABLE_SLOTS_DEF;
	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 820;
	localparam int KEY_POOL_N = 24;
	localparam int LOCK_POOL_N = 8;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	typedef enum {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          func;
	logic [KEY_W-1:0]    site_key;
	logic [LOCK_W-1:0]   lock_id;
	logic [TICK_W-1:0]   acquire_tick;
	logic [TICK_W-1:0]   now_tick;
	logic [SLOT_W-1:0]   read_slot;
	logic                out_valid;
	logic                out_ready;
	logic [STAT_W-1:0]   status;
	logic [SLOT_W-1:0]   slot_index;
	logic [KEY_W-1:0]    key_out;
	logic [LOCK_W-1:0]   lock_id_out;
	logic [TICK_W-1:0]   take_count;
	logic [TICK_W-1:0]   total_hold;
	logic [TICK_W-1:0]   max_hold;
	logic [REM_W-1:0]    removed_count;
	int                  results_pending;
	int                  failures;

	pace_t pace;
	int items_sent;
	int stall_cycles;
	logic [KEY_W-1:0]  key_pool  [KEY_POOL_N];
	logic [LOCK_W-1:0] lock_pool [LOCK_POOL_N];
	logic [KEY_W-1:0]  fill_key  [SLOTS];
	logic [LOCK_W-1:0] fill_lock [SLOTS];

	lock_site_stats_hash_table_unit uut (.*);
	lock_site_stats_checker checker_i (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int send_gap_pct();
		return (pace == PACE_SEND_GAPS) ? 85 : (pace == PACE_BOTH) ? 33 : 0;
	endfunction

	function automatic int recv_stall_pct();
		return (pace == PACE_RECV_STALLS) ? 85 : (pace == PACE_BOTH) ? 33 : 0;
	endfunction

	function automatic logic [TICK_W-1:0] rand_tick();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[TICK_W-1:0];
	endfunction

	function automatic logic [KEY_W-1:0] usable_key(input logic [KEY_W-1:0] k);
		return (k <= KEY_TOMB) ? k + 2 : k;
	endfunction

	function automatic logic [KEY_W-1:0] pick_site_key();
		int roll;
		roll = $urandom_range(99);
		if (roll < 80)
			return key_pool[$urandom_range(KEY_POOL_N-1)];
		else if (roll < 98)
			return $urandom();
		else
			return ($urandom_range(1) != 0) ? KEY_TOMB : KEY_EMPTY;
	endfunction

	function automatic logic [LOCK_W-1:0] pick_lock();
		logic [LOCK_W-1:0] l;
		if ($urandom_range(99) < 85)
			return lock_pool[$urandom_range(LOCK_POOL_N-1)];
		l = $urandom();
		return (l == 0) ? 1 : l;
	endfunction

	// one transaction on the input channel, with sender gaps per the current pace
	task automatic send_item(input logic [1:0] f, input logic [KEY_W-1:0] k,
			input logic [LOCK_W-1:0] l, input logic [TICK_W-1:0] a,
			input logic [TICK_W-1:0] nw, input logic [SLOT_W-1:0] rs);
		pace = pace_t'((items_sent / 64) % 4);
		while ($urandom_range(99) < send_gap_pct()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		site_key <= k;
		lock_id <= l;
		acquire_tick <= a;
		now_tick <= nw;
		read_slot <= rs;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic record(input logic [KEY_W-1:0] k, input logic [LOCK_W-1:0] l,
			input logic [TICK_W-1:0] a, input logic [TICK_W-1:0] nw);
		send_item(FUNC_RECORD, k, l, a, nw, SLOT_W'($urandom()));
	endtask

	task automatic delist(input logic [LOCK_W-1:0] l);
		send_item(FUNC_DELIST, $urandom(), l, rand_tick(), rand_tick(), SLOT_W'($urandom()));
	endtask

	task automatic read_entry(input logic [SLOT_W-1:0] s);
		send_item(FUNC_READ, $urandom(), pick_lock(), rand_tick(), rand_tick(), s);
	endtask

	task automatic noise();
		send_item(FUNC_UNUSED, $urandom(), pick_lock(), rand_tick(), rand_tick(),
			SLOT_W'($urandom()));
	endtask

	task automatic random_record(input logic [KEY_W-1:0] k, input logic [LOCK_W-1:0] l);
		logic [TICK_W-1:0] a;
		logic [TICK_W-1:0] nw;
		a = rand_tick();
		case ($urandom_range(3))
			0, 1: nw = a + TICK_W'($urandom_range(5000));
			2: nw = rand_tick();
			default: nw = a - TICK_W'($urandom_range(100, 1));
		endcase
		record(k, l, a, nw);
	endtask

	// hold off the sender until every outstanding result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct());

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("lock_site_stats_hash_table_unit_tb failed");
				$finish;
			end
		end
	end

	initial begin
		int i;
		int count;
		int roll;
		logic [KEY_W-1:0] k;
		pace = PACE_FULL;
		items_sent = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		out_ready <= 1'b0;
		func <= FUNC_READ;
		site_key <= '0;
		lock_id <= '0;
		acquire_tick <= '0;
		now_tick <= '0;
		read_slot <= '0;
		// second block of keys shares low bits with the first to force probe chains
		for (i = 0; i < KEY_POOL_N; i++) begin
			if (i < 8)
				key_pool[i] = usable_key($urandom());
			else if (i < 16)
				key_pool[i] = {23'($urandom()), key_pool[i-8][SLOT_W-1:0]};
			else
				key_pool[i] = $urandom_range(600, 2);
			key_pool[i] = usable_key(key_pool[i]);
		end
		lock_pool[0] = 1;
		lock_pool[1] = '1;
		for (i = 2; i < LOCK_POOL_N; i++)
			lock_pool[i] = $urandom_range(32'hFFFF_FFFF, 1);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		read_entry('0);
		record(KEY_EMPTY, lock_pool[0], 0, 10);
		record(KEY_TOMB, lock_pool[1], 0, 10);
		record('1, '1, 0, TICK_MAX);
		record('1, '1, 0, TICK_MAX);           // total wraps
		record('1, 1, TICK_MAX, 0);            // same key, other lock, negative hold
		record(2, 5, 100, 150);
		record(514, 5, 200, 260);              // collides with key 2
		record(2, 5, 300, 301);
		delist(5);
		record(514, 5, 400, 400);              // first tombstone on the path is reused
		read_entry(5);
		read_entry(2);
		read_entry('1);
		read_entry(9'd510);
		noise();
		delist(32'h0000_0007);
		record(32'hAAAA_AAAA, 32'h5555_5555, {1'b0, {31{2'b10}}}, {1'b1, {31{2'b01}}});
		record(32'h5555_5555, 32'hAAAA_AAAA, {1'b1, {31{2'b01}}}, {1'b0, {31{2'b10}}});
		read_entry(9'h155);
		read_entry(9'h0AA);
		drain_results();

		count = 0;
		while (count < RANDOM_ITEMS) begin
			roll = $urandom_range(99);
			if (roll < 68)
				random_record(pick_site_key(), pick_lock());
			else if (roll < 76)
				delist(pick_lock());
			else if (roll < 96)
				read_entry(SLOT_W'($urandom()));
			else
				noise();
			if (roll < 96)
				count++;
		end
		drain_results();

		// one fresh key per slot leaves no free slot behind
		for (i = 0; i < SLOTS; i++) begin
			fill_key[i] = {23'($urandom_range(23'h7F_FFFF, 1)), SLOT_W'(i)};
			fill_lock[i] = lock_pool[$urandom_range(LOCK_POOL_N-1)];
			random_record(fill_key[i], fill_lock[i]);
		end
		for (i = 0; i < 6; i++) begin
			k = {23'($urandom_range(23'h7F_FFFF, 1)), SLOT_W'($urandom())};
			random_record(k, pick_lock());
			count = $urandom_range(SLOTS-1);
			random_record(fill_key[count], fill_lock[count]);
		end
		read_entry(SLOT_W'($urandom()));
		drain_results();
		for (i = 0; i < LOCK_POOL_N; i++)
			delist(lock_pool[i]);
		for (i = 0; i < 30; i++) begin
			if (i % 3 == 2) begin
				read_entry(SLOT_W'($urandom()));
			end else begin
				count = $urandom_range(SLOTS-1);
				random_record(fill_key[count], fill_lock[count]);
			end
		end

		drain_results();
		repeat (2 * SLOTS + 16) @(posedge clk);
		if (failures == 0)
			$display("lock_site_stats_hash_table_unit_tb passed");
		else
			$display("lock_site_stats_hash_table_unit_tb failed");
		$finish;
	end

endmodule
